// ===== rtl/sync_probe_deframer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// sync probe deframer assertion macros
// concurrent check helpers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef SYNC_PROBE_DEFRAMER_UNIT_DEFINES_SVH
`define SYNC_PROBE_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTH
// expr must never hold outside reset
`define SPD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("spd check failed: never condition seen");
// ante implies cons in the same cycle
`define SPD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spd check failed: implication broken");
`else
`define SPD_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define SPD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/spd_pkg.sv =====
// ---------------------------------------------------------------------------
// spd_pkg
// shared constants and types of the sync probe deframer
// ---------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

	// frame geometry
	localparam int WinLen     = 12;
	localparam int ReplyLen   = 24;
	localparam int IdxW       = $clog2(ReplyLen);
	localparam int FillW      = 4;
	localparam int QueueDepth = 2;

	// header magics, one byte each
	localparam logic [7:0] ChM = 8'h4D;
	localparam logic [7:0] ChV = 8'h56;
	localparam logic [7:0] ChA = 8'h41;
	localparam logic [7:0] ChK = 8'h4B;
	localparam logic [7:0] ChP = 8'h50;
	localparam logic [7:0] ChB = 8'h42;

	// reply magic "MVTS", first byte in the low bits
	localparam logic [31:0] ReplyMagic = 32'h5354_564D;

	// one pending reply: echoed probe payload and capture time, both little-endian
	typedef struct packed {
		logic [63:0] stamp;
		logic [63:0] payload;
	} desc_t;

	// front to queue write
	typedef struct packed {
		logic  valid;
		desc_t desc;
	} push_t;

	// queue occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// ===== rtl/spd_front.sv =====
// ---------------------------------------------------------------------------
// spd_front
// byte window, header classification and reply descriptor push
// ---------------------------------------------------------------------------
`default_nettype none

module spd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [63:0]   time_now,
	output spd_pkg::push_t     push
);

	logic [7:0] win_q [spd_pkg::WinLen];
	logic [7:0] win_app [spd_pkg::WinLen];
	logic [spd_pkg::FillW-1:0] fill_q;
	logic completes;
	logic is_ack;
	logic is_probe;

	// append the new byte and look at the header
	always_comb begin
		for (int k = 0; k < spd_pkg::WinLen; k++) begin
			win_app[k] = win_q[k];
		end
		win_app[fill_q] = rx_byte;
		completes = (fill_q == spd_pkg::FillW'(spd_pkg::WinLen - 1));
		is_ack = completes && win_app[0] == spd_pkg::ChM && win_app[1] == spd_pkg::ChV &&
			win_app[2] == spd_pkg::ChA && win_app[3] == spd_pkg::ChK;
		is_probe = completes && win_app[0] == spd_pkg::ChM && win_app[1] == spd_pkg::ChV &&
			win_app[2] == spd_pkg::ChP && win_app[3] == spd_pkg::ChB;
	end

	// reply descriptor for a completed probe
	always_comb begin
		push.valid = accept && is_probe;
		push.desc.stamp = time_now;
		for (int k = 0; k < 8; k++) begin
			push.desc.payload[8*k +: 8] = win_app[4 + k];
		end
	end

	// fill count: full frame consumed, or oldest byte dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (is_ack || is_probe) begin
				fill_q <= '0;
			end else if (completes) begin
				fill_q <= spd_pkg::FillW'(spd_pkg::WinLen - 1);
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// window bytes, shifted down by one on resync
	always_ff @(posedge clk) begin
		if (accept) begin
			if (completes && !is_ack && !is_probe) begin
				for (int k = 0; k < spd_pkg::WinLen - 1; k++) begin
					win_q[k] <= win_app[k + 1];
				end
				win_q[spd_pkg::WinLen - 1] <= win_app[spd_pkg::WinLen - 1];
			end else begin
				for (int k = 0; k < spd_pkg::WinLen; k++) begin
					win_q[k] <= win_app[k];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/spd_queue.sv =====
// ---------------------------------------------------------------------------
// spd_queue
// short fifo of pending reply descriptors between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module spd_queue #(
	parameter int DEPTH = spd_pkg::QueueDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire spd_pkg::push_t push,
	input  wire logic          pop,
	output spd_pkg::desc_t     head,
	output spd_pkg::qstat_t    stat
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	spd_pkg::desc_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign stat.full  = (count_q == CntW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// descriptor storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.desc;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/spd_back.sv =====
// ---------------------------------------------------------------------------
// spd_back
// reply serializer, one byte per transfer into an output register
// ---------------------------------------------------------------------------
`default_nettype none

module spd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [31:0]   camera_id,
	input  wire spd_pkg::desc_t  head,
	input  wire spd_pkg::qstat_t stat,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         tx_byte,
	output logic               last_byte
);

	logic [spd_pkg::IdxW-1:0] idx_q;
	logic                     valid_q;
	logic [7:0]               byte_q;
	logic                     last_q;
	logic                     load;
	logic                     is_last;
	logic [7:0]               cur_byte;
	logic [31:0]              cam_sh;
	logic [63:0]              pay_sh;
	logic [63:0]              stamp_sh;
	logic [31:0]              magic_sh;

	assign load    = !stat.empty && (!valid_q || !out_stall);
	assign is_last = (idx_q == spd_pkg::IdxW'(spd_pkg::ReplyLen - 1));
	assign pop     = load && is_last;

	// byte select by reply position
	always_comb begin
		magic_sh = spd_pkg::ReplyMagic >> {idx_q[1:0], 3'b000};
		cam_sh   = camera_id >> {idx_q[1:0], 3'b000};
		pay_sh   = head.payload >> {idx_q[2:0], 3'b000};
		stamp_sh = head.stamp >> {idx_q[2:0], 3'b000};
		if (idx_q < spd_pkg::IdxW'(4)) begin
			cur_byte = magic_sh[7:0];
		end else if (idx_q < spd_pkg::IdxW'(8)) begin
			cur_byte = cam_sh[7:0];
		end else if (idx_q < spd_pkg::IdxW'(16)) begin
			cur_byte = pay_sh[7:0];
		end else begin
			cur_byte = stamp_sh[7:0];
		end
	end

	// position counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			last_q <= is_last;
		end
	end

	assign out_valid = valid_q;
	assign tx_byte   = byte_q;
	assign last_byte = last_q;

endmodule

`default_nettype wire

// ===== rtl/sync_probe_deframer_unit.sv =====
// a completed probe is first written into the reply queue; the serializer then
//   loads the first reply byte into the output register and raises out_valid;
//   24 bytes in all, one per cycle without stall
// throughput: one input byte per cycle while the reply queue has room; output is
//   one byte per cycle while a reply is queued and out_stall is low
// reset: window empty, camera_id zero, reply queue and output register empty
// ---------------------------------------------------------------------------
// sync_probe_deframer_unit
// deframes a hub byte stream, drops acks, answers probes with a 24-byte reply
// ---------------------------------------------------------------------------
`default_nettype none

`include "sync_probe_deframer_unit_defines.svh"

module sync_probe_deframer_unit #(
	parameter int QUEUE_DEPTH = spd_pkg::QueueDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// byte input
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [63:0]   time_now,
	// reply output
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         tx_byte,
	output logic               last_byte,
	// camera id write
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [31:0]   cfg_data
);

	logic            accept;
	logic            pop;
	logic [31:0]     camera_id_q;
	spd_pkg::push_t  push;
	spd_pkg::desc_t  head;
	spd_pkg::qstat_t stat;

	assign cfg_ready = 1'b1;
	assign in_stall  = stat.full;
	assign accept    = in_valid && !in_stall;

	// camera id register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			camera_id_q <= cfg_data;
		end
	end

	spd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.time_now (time_now),
		.push     (push)
	);

	spd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	spd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.camera_id (camera_id_q),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.last_byte (last_byte)
	);

	// checks
	`SPD_ASSERT_NEVER(a_no_push_full, clk, arst_n, push.valid && stat.full)
	`SPD_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && stat.empty)
	`SPD_ASSERT_IMPLY(a_mid_reply_held, clk, arst_n, out_valid && !last_byte, !stat.empty)

endmodule

`default_nettype wire

// ===== bench/sync_probe_deframer_unit_tb.sv =====
// ---------------------------------------------------------------------------
// sync_probe_deframer_unit_tb
// Drives a hub byte stream into the deframer. The stream is mostly probe and
// ack frames with random payloads, mixed with broken headers and noise bytes.
// A scoreboard tracks the 12-byte window and the camera id. From them it
// builds each 24-byte reply and checks the reply bytes in order.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_probe_deframer_unit_tb;

	// header magics, first byte in the low bits
	localparam logic [31:0] ProbeMagic = {spd_pkg::ChB, spd_pkg::ChP, spd_pkg::ChV,
		spd_pkg::ChM};
	localparam logic [31:0] AckMagic   = {spd_pkg::ChK, spd_pkg::ChA, spd_pkg::ChV,
		spd_pkg::ChM};
	localparam int          SettleCyc  = 8;
	localparam int          MaxReports = 10;

	typedef enum int {FR_PROBE, FR_ACK, FR_BROKEN, FR_NOISE} frame_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} reply_byte_t;

	// mirror of the deframer window and the replies it owes
	class reply_scoreboard_t;
		logic [7:0]  win [spd_pkg::WinLen];
		int          fill;
		logic [31:0] camera_id;
		reply_byte_t owed [$];
		int          failures;

		function new();
			fill      = 0;
			camera_id = '0;
			failures  = 0;
		endfunction

		function bit head_is(logic [31:0] magic);
			return win[0] == magic[7:0] && win[1] == magic[15:8] &&
				win[2] == magic[23:16] && win[3] == magic[31:24];
		endfunction

		function void drop_oldest();
			for (int k = 0; k < spd_pkg::WinLen - 1; k++)
				win[k] = win[k + 1];
			fill = spd_pkg::WinLen - 1;
		endfunction

		// note one accepted input transfer
		function void take_byte(logic [7:0] rx, logic [63:0] stamp);
			reply_byte_t rb;
			if (fill >= spd_pkg::WinLen)
				drop_oldest();
			win[fill] = rx;
			fill++;
			if (fill < spd_pkg::WinLen)
				return;
			if (head_is(AckMagic)) begin
				fill = 0;
				return;
			end
			if (!head_is(ProbeMagic)) begin
				drop_oldest();
				return;
			end
			for (int k = 0; k < spd_pkg::ReplyLen; k++) begin
				if (k < 4)
					rb.data = spd_pkg::ReplyMagic[8*k +: 8];
				else if (k < 8)
					rb.data = camera_id[8*(k-4) +: 8];
				else if (k < 16)
					rb.data = win[k - 4];
				else
					rb.data = stamp[8*(k-16) +: 8];
				rb.last = (k == spd_pkg::ReplyLen - 1);
				owed.push_back(rb);
			end
			fill = 0;
		endfunction

		// compare one output transfer with the oldest owed byte
		function void check_byte(logic [7:0] tx, logic last);
			reply_byte_t rb;
			if (owed.size() == 0) begin
				failures++;
				if (failures <= MaxReports)
					$display("unexpected reply byte: data %h last %b", tx, last);
				return;
			end
			rb = owed.pop_front();
			if (tx !== rb.data || last !== rb.last) begin
				failures++;
				if (failures <= MaxReports)
					$display("reply mismatch: data exp %h got %h, last exp %b got %b",
						rb.data, tx, rb.last, last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic [63:0] time_now;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  tx_byte;
	logic        last_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	reply_scoreboard_t sb = new();
	bit                steady;
	int                items_sent;

	sync_probe_deframer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.time_now  (time_now),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.last_byte (last_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 37);
	end

	// output transfer monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_byte(tx_byte, last_byte);
	end

	// one input transfer, then, when not steady, sometimes a random gap
	task automatic send_byte(logic [7:0] b, logic [63:0] stamp);
		in_valid <= 1'b1;
		rx_byte  <= b;
		time_now <= stamp;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		sb.take_byte(b, stamp);
		items_sent++;
		if (!steady && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	task automatic send_rand_stamp(logic [7:0] b);
		send_byte(b, {$urandom, $urandom});
	endtask

	// magic header then eight random payload bytes
	task automatic send_magic_frame(logic [31:0] magic);
		for (int k = 0; k < 4; k++)
			send_rand_stamp(magic[8*k +: 8]);
		for (int k = 0; k < 8; k++)
			send_rand_stamp(8'($urandom_range(0, 255)));
	endtask

	// sender holds off until every owed reply byte is out
	task automatic wait_replies_done();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (SettleCyc) @(posedge clk);
	endtask

	task automatic write_camera_id(logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		sb.camera_id = value;
		cfg_valid <= 1'b0;
	endtask

	// random frame mix: mostly good frames, some broken headers and noise
	task automatic run_traffic(int n_items);
		int          target;
		int          pick;
		int          keep;
		frame_kind_t kind;
		logic [31:0] magic;
		target = items_sent + n_items;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			kind = pick < 45 ? FR_PROBE : pick < 65 ? FR_ACK :
				pick < 80 ? FR_BROKEN : FR_NOISE;
			case (kind)
				FR_PROBE: send_magic_frame(ProbeMagic);
				FR_ACK:   send_magic_frame(AckMagic);
				FR_BROKEN: begin
					magic = $urandom_range(0, 1) ? ProbeMagic : AckMagic;
					keep  = $urandom_range(1, 3);
					for (int k = 0; k < keep; k++)
						send_rand_stamp(magic[8*k +: 8]);
					send_rand_stamp(8'($urandom_range(0, 255)));
				end
				default: begin
					repeat ($urandom_range(1, 4))
						send_rand_stamp(8'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	// main sequence
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		rx_byte    = '0;
		time_now   = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		steady     = 1'b0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_camera_id(32'hFFFF_FFFF);

		// leading junk byte fills the window first, is dropped, then the probe completes
		send_byte(8'hFF, 64'h0);
		for (int k = 0; k < 4; k++)
			send_byte(ProbeMagic[8*k +: 8], 64'h0);
		for (int k = 0; k < 8; k++)
			send_byte(k[0] ? 8'hFF : 8'h00, 64'h0);
		// stray byte ahead of the ack, dropped on resync
		send_byte(8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
		// ack frame consumed silently
		for (int k = 0; k < 4; k++)
			send_byte(AckMagic[8*k +: 8], 64'h0);
		for (int k = 0; k < 8; k++)
			send_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
		wait_replies_done();

		write_camera_id(32'h0000_0000);
		run_traffic(85);
		wait_replies_done();

		write_camera_id($urandom);
		run_traffic(85);
		wait_replies_done();

		write_camera_id(32'h8000_0001);
		run_traffic(75);
		wait_replies_done();

		// long stretch with no idling on either side
		steady = 1'b1;
		write_camera_id($urandom);
		run_traffic(80);
		wait_replies_done();

		if (sb.failures == 0 && sb.owed.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#(8 * 200000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/spd_pkg.sv
rtl/spd_front.sv
rtl/spd_queue.sv
rtl/spd_back.sv
rtl/sync_probe_deframer_unit.sv
bench/sync_probe_deframer_unit_tb.sv
